FILE: sv/u8u16_pkg.sv
// shared types, constants and table functions for the utf-8 to utf-16 decoder
package u8u16_pkg;

    localparam logic [15:0] REPL_UNIT   = 16'hFFFD;
    localparam logic [15:0] HI_SURR     = 16'hD800;
    localparam logic [15:0] LO_SURR     = 16'hDC00;
    localparam logic [30:0] SURR_FIRST  = 31'h0000D800;
    localparam logic [30:0] SURR_LAST   = 31'h0000DFFF;
    localparam logic [30:0] BMP_LAST    = 31'h0000FFFF;
    localparam logic [30:0] SUPP_FIRST  = 31'h00010000;
    localparam logic [30:0] UNI_LAST    = 31'h0010FFFF;
    localparam logic [2:0]  KIND_MAX    = 3'd4;

    typedef struct packed {
        logic        in_seq;
        logic [2:0]  rem;
        logic [2:0]  kind;
        logic [30:0] acc;
    } t_state;

    typedef struct packed {
        logic        last;
        logic        repl;
        logic [15:0] code;
    } t_unit;

    typedef struct packed {
        logic [1:0] cnt;
        t_unit      unit0;
        t_unit      unit1;
    } t_dec_out;

    // payload bits kept from a lead byte, by sequence length minus 2
    function automatic logic [7:0] lead_mask(input logic [2:0] kind);
        logic [7:0] m;
        case (kind)
            3'd0:    m = 8'h1F;
            3'd1:    m = 8'h0F;
            3'd2:    m = 8'h07;
            3'd3:    m = 8'h03;
            default: m = 8'h01;
        endcase
        return m;
    endfunction

    // smallest value that is not overlong for the sequence length
    function automatic logic [30:0] min_value(input logic [2:0] kind);
        logic [30:0] v;
        case (kind)
            3'd0:    v = 31'h00000080;
            3'd1:    v = 31'h00000800;
            3'd2:    v = 31'h00010000;
            3'd3:    v = 31'h00200000;
            default: v = 31'h04000000;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/utf8_to_utf16_decoder.sv
// utf-8 to utf-16 transcoder top level: input register, decode, output queue
//
// usage:
//   slave channel takes one utf-8 byte per transaction on i_s_axis_tdata.
//   master channel gives one utf-16 code unit per transaction: tdata is the
//   unit, tuser flags a replacement for malformed input, tlast marks the
//   final unit that one input byte causes.
//   a lead or continuation byte that does not finish a sequence gives no
//   output transaction; a finished supplementary value or a broken sequence
//   followed by a decodable byte gives two.
// path: a byte's transaction loads the input register, its units then enter
//   the output queue, and the queue offers them to the receiver.
// throughput: one byte per cycle while the receiver is ready and each byte
//   gives at most one unit; a byte giving two units needs the queue empty
//   once this cycle's unit leaves, else it waits for the single output port.
// reset (synchronous, active low) empties the input register and the output
//   queue and leaves the decoder outside any sequence.
// when the receiver stalls, queued units hold; once the queue cannot take
//   the next byte's units, o_s_axis_tready drops after the input register
//   fills.
module utf8_to_utf16_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [15:0] code_unit
    output logic [0:0]  o_m_axis_tuser,   // [0] is_replacement
    output logic        o_m_axis_tlast
);
    import u8u16_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_state     r_state;
    t_state     n_state;
    t_unit      r_q [2];
    t_unit      n_q [2];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_state     dec_state;
    t_dec_out   dec;
    logic       pop;
    logic [1:0] free;
    logic       fire;
    t_unit      res_u [2];

    u8u16_decode u_decode (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .o_state (dec_state),
        .o_res   (dec)
    );

    assign pop  = (r_cnt != 2'd0) && i_m_axis_tready;
    assign free = 2'd2 - r_cnt + {1'b0, pop};
    assign fire = r_in_valid && (dec.cnt <= free);

    assign o_s_axis_tready = !r_in_valid || fire;

    assign res_u[0] = dec.unit0;
    assign res_u[1] = dec.unit1;

    always_comb begin
        n_q     = r_q;
        n_cnt   = r_cnt;
        n_state = r_state;
        if (pop) begin
            n_q[0] = r_q[1];
            n_cnt  = r_cnt - 2'd1;
        end
        if (fire) begin
            n_state = dec_state;
            for (int i = 0; i < 2; i++) begin
                if (i < int'(dec.cnt)) begin
                    n_q[n_cnt[0]] = res_u[i];
                    n_cnt         = n_cnt + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cnt      <= 2'd0;
            r_state    <= '0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            r_cnt   <= n_cnt;
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
        r_q <= n_q;
    end

    assign o_m_axis_tvalid   = (r_cnt != 2'd0);
    assign o_m_axis_tdata    = r_q[0].code;
    assign o_m_axis_tuser[0] = r_q[0].repl;
    assign o_m_axis_tlast    = r_q[0].last;

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output queue count out of range");

    a_pair_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && dec.cnt == 2'd2 |=> r_cnt == 2'd2)
        else $error("two-unit result did not fill the queue");

    a_seq_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.in_seq |-> r_state.rem != 3'd0)
        else $error("open sequence with no bytes remaining");

    a_repl_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata == REPL_UNIT)
        else $error("replacement flag on a unit other than fffd");

    a_dec_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> dec.cnt != 2'd3)
        else $error("decode produced more than two units");
`endif

endmodule

FILE: sv/u8u16_decode.sv
// combinational decode of one utf-8 byte against the sequence state
module u8u16_decode (
    input  u8u16_pkg::t_state   i_state,
    input  logic [7:0]          i_byte,
    output u8u16_pkg::t_state   o_state,
    output u8u16_pkg::t_dec_out o_res
);
    import u8u16_pkg::*;

    t_state      nxt;
    t_dec_out    res;
    t_state      idle_nxt;
    logic        idle_emit;
    t_unit       idle_unit;
    logic [30:0] acc_sh;
    logic [2:0]  kind_c;
    logic [20:0] off;
    logic [2:0]  lead_kind;
    logic [2:0]  rem_dec;

    // fresh decode of the byte as if no sequence were open
    always_comb begin
        idle_nxt           = i_state;
        idle_nxt.in_seq    = 1'b0;
        idle_nxt.rem       = 3'd0;
        idle_emit          = 1'b1;
        idle_unit          = '0;
        lead_kind          = 3'd0;
        if (i_byte[7] == 1'b0) begin
            idle_unit.code = {8'h00, i_byte};
        end else if (i_byte inside {[8'h80:8'hBF], 8'hFE, 8'hFF}) begin
            idle_unit.code = REPL_UNIT;
            idle_unit.repl = 1'b1;
        end else begin
            idle_emit = 1'b0;
            if (i_byte inside {[8'hC0:8'hDF]}) begin
                lead_kind = 3'd0;
            end else if (i_byte inside {[8'hE0:8'hEF]}) begin
                lead_kind = 3'd1;
            end else if (i_byte inside {[8'hF0:8'hF7]}) begin
                lead_kind = 3'd2;
            end else if (i_byte inside {[8'hF8:8'hFB]}) begin
                lead_kind = 3'd3;
            end else begin
                lead_kind = 3'd4;
            end
            idle_nxt.kind   = lead_kind;
            idle_nxt.rem    = lead_kind + 3'd1;
            idle_nxt.acc    = {23'd0, i_byte & lead_mask(lead_kind)};
            idle_nxt.in_seq = 1'b1;
        end
    end

    always_comb begin
        nxt     = i_state;
        res     = '0;
        acc_sh  = {i_state.acc[24:0], i_byte[5:0]};
        rem_dec = i_state.rem - 3'd1;
        kind_c  = (i_state.kind > KIND_MAX) ? KIND_MAX : i_state.kind;
        off     = acc_sh[20:0] - SUPP_FIRST[20:0];
        if (i_state.in_seq && i_state.rem != 3'd0) begin
            if (i_byte[7:6] == 2'b10) begin
                nxt.acc = acc_sh;
                nxt.rem = rem_dec;
                if (rem_dec == 3'd0) begin
                    nxt.in_seq = 1'b0;
                    if (acc_sh < min_value(kind_c) ||
                        (acc_sh >= SURR_FIRST && acc_sh <= SURR_LAST)) begin
                        res.cnt        = 2'd1;
                        res.unit0.code = REPL_UNIT;
                        res.unit0.repl = 1'b1;
                    end else if (acc_sh >= SUPP_FIRST && acc_sh <= UNI_LAST) begin
                        res.cnt        = 2'd2;
                        res.unit0.code = HI_SURR | {6'd0, off[19:10]};
                        res.unit1.code = LO_SURR | {6'd0, off[9:0]};
                    end else if (acc_sh > BMP_LAST) begin
                        res.cnt        = 2'd1;
                        res.unit0.code = REPL_UNIT;
                        res.unit0.repl = 1'b1;
                    end else begin
                        res.cnt        = 2'd1;
                        res.unit0.code = acc_sh[15:0];
                    end
                end
            end else begin
                // broken sequence: replacement, then the byte decodes afresh
                nxt            = idle_nxt;
                res.unit0.code = REPL_UNIT;
                res.unit0.repl = 1'b1;
                if (idle_emit) begin
                    res.cnt   = 2'd2;
                    res.unit1 = idle_unit;
                end else begin
                    res.cnt = 2'd1;
                end
            end
        end else begin
            nxt = idle_nxt;
            if (idle_emit) begin
                res.cnt   = 2'd1;
                res.unit0 = idle_unit;
            end
        end
        if (res.cnt == 2'd1) begin
            res.unit0.last = 1'b1;
        end else if (res.cnt == 2'd2) begin
            res.unit1.last = 1'b1;
        end
    end

    assign o_state = nxt;
    assign o_res   = res;

endmodule

FILE: tb/sv/testbench.sv
// self-checking testbench for the utf-8 to utf-16 decoder
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import u8u16_pkg::*;

    localparam int N_DIRECTED  = 24;
    localparam int N_RANDOM    = 826;
    localparam int N_QUIET     = 120;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 80;
    localparam int STALL_LIMIT = 2000;

    // shortest non-overlong value by sequence length minus 2
    localparam logic [30:0] SHORTEST [5] = '{31'h80, 31'h800, 31'h10000, 31'h200000,
                                             31'h4000000};

    typedef struct packed {
        logic [7:0]  data;
        logic        typed;     // expectation written out below
        logic        has_unit;  // typed rows give at most one unit
        logic [15:0] code;
        logic        repl;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [N_DIRECTED] = '{
        '{8'h00, 1'b1, 1'b1, 16'h0000,  1'b0},  // ascii extremes
        '{8'h7F, 1'b1, 1'b1, 16'h007F,  1'b0},
        '{8'h80, 1'b1, 1'b1, REPL_UNIT, 1'b1},  // stray continuation
        '{8'hBF, 1'b1, 1'b1, REPL_UNIT, 1'b1},
        '{8'hFE, 1'b1, 1'b1, REPL_UNIT, 1'b1},  // never valid in utf-8
        '{8'hFF, 1'b1, 1'b1, REPL_UNIT, 1'b1},
        '{8'hC0, 1'b1, 1'b0, 16'h0000,  1'b0},  // overlong two-byte nul
        '{8'h80, 1'b1, 1'b1, REPL_UNIT, 1'b1},
        '{8'hED, 1'b1, 1'b0, 16'h0000,  1'b0},  // encoded surrogate d800
        '{8'hA0, 1'b1, 1'b0, 16'h0000,  1'b0},
        '{8'h80, 1'b1, 1'b1, REPL_UNIT, 1'b1},
        '{8'hF0, 1'b1, 1'b0, 16'h0000,  1'b0},  // u+1f600, surrogate pair
        '{8'h9F, 1'b1, 1'b0, 16'h0000,  1'b0},
        '{8'h98, 1'b1, 1'b0, 16'h0000,  1'b0},
        '{8'h80, 1'b0, 1'b0, 16'h0000,  1'b0},
        '{8'hF4, 1'b1, 1'b0, 16'h0000,  1'b0},  // 0x110000, past the last code point
        '{8'h90, 1'b1, 1'b0, 16'h0000,  1'b0},
        '{8'h80, 1'b1, 1'b0, 16'h0000,  1'b0},
        '{8'h80, 1'b1, 1'b1, REPL_UNIT, 1'b1},
        '{8'hEF, 1'b1, 1'b0, 16'h0000,  1'b0},  // genuine u+fffd is not flagged
        '{8'hBF, 1'b1, 1'b0, 16'h0000,  1'b0},
        '{8'hBD, 1'b1, 1'b1, 16'hFFFD,  1'b0},
        '{8'hFC, 1'b1, 1'b0, 16'h0000,  1'b0},  // six-byte lead broken by ascii
        '{8'h41, 1'b0, 1'b0, 16'h0000,  1'b0}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic [7:0]  s_data;
    logic        rx_ready;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [15:0] o_m_axis_tdata;
    logic [0:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;

    // decoder state as seen by the predictor
    logic        seq_open   = 1'b0;
    logic [2:0]  seq_left   = 3'd0;
    logic [2:0]  seq_kind   = 3'd0;
    logic [30:0] seq_value  = 31'd0;

    t_unit       byte_units[$];
    t_unit       pending_units[$];

    int bytes_sent    = 0;
    int units_checked = 0;
    int pairs_seen    = 0;
    int repl_units    = 0;
    int mismatches    = 0;
    int idle_cycles   = 0;

    wire quiet = bytes_sent >= N_DIRECTED + N_RANDOM - N_QUIET;

    utf8_to_utf16_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (rx_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic add_unit(input logic [15:0] code, input logic repl);
        t_unit u;
        u.code = code;
        u.repl = repl;
        u.last = 1'b0;
        byte_units.push_back(u);
    endtask

    // byte seen outside any sequence
    task automatic decode_fresh(input logic [7:0] b);
        logic [2:0] k;
        if (b < 8'h80) begin
            add_unit({8'h00, b}, 1'b0);
        end else if (b < 8'hC0 || b >= 8'hFE) begin
            add_unit(REPL_UNIT, 1'b1);
        end else begin
            if (b < 8'hE0)      k = 3'd0;
            else if (b < 8'hF0) k = 3'd1;
            else if (b < 8'hF8) k = 3'd2;
            else if (b < 8'hFC) k = 3'd3;
            else                k = 3'd4;
            seq_kind  = k;
            seq_left  = k + 3'd1;
            seq_value = {23'd0, b & (8'hFF >> (k + 3'd3))};
            seq_open  = 1'b1;
        end
    endtask

    // units that one input byte gives, left in byte_units
    task automatic decode_utf8_byte(input logic [7:0] b);
        logic [30:0] v;
        logic [30:0] off;
        t_unit       u;
        byte_units.delete();
        if (seq_open && seq_left != 3'd0) begin
            if (b[7:6] == 2'b10) begin
                seq_value = {seq_value[24:0], b[5:0]};
                seq_left  = seq_left - 3'd1;
                if (seq_left == 3'd0) begin
                    v = seq_value;
                    if (v < SHORTEST[seq_kind] || (v >= SURR_FIRST && v <= SURR_LAST)) begin
                        add_unit(REPL_UNIT, 1'b1);
                    end else if (v >= SUPP_FIRST && v <= UNI_LAST) begin
                        off = v - SUPP_FIRST;
                        add_unit(HI_SURR | {6'd0, off[19:10]}, 1'b0);
                        add_unit(LO_SURR | {6'd0, off[9:0]}, 1'b0);
                        pairs_seen++;
                    end else if (v > BMP_LAST) begin
                        add_unit(REPL_UNIT, 1'b1);
                    end else begin
                        add_unit(v[15:0], 1'b0);
                    end
                    seq_open = 1'b0;
                end
            end else begin
                // broken sequence: flag it, then start over on this byte
                add_unit(REPL_UNIT, 1'b1);
                seq_open = 1'b0;
                seq_left = 3'd0;
                decode_fresh(b);
            end
        end else begin
            seq_open = 1'b0;
            seq_left = 3'd0;
            decode_fresh(b);
        end
        if (byte_units.size() != 0) begin
            u = byte_units.pop_back();
            u.last = 1'b1;
            byte_units.push_back(u);
        end
    endtask

    // offer one byte, wait for its transaction, then queue what it should give
    task automatic feed_byte(input logic [7:0] b, input t_dir_row row);
        t_unit u;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        bytes_sent++;
        @(negedge i_clk);
        decode_utf8_byte(b);
        if (row.typed) begin
            if (row.has_unit) begin
                u.code = row.code;
                u.repl = row.repl;
                u.last = 1'b1;
                pending_units.push_back(u);
            end
        end else begin
            foreach (byte_units[i]) pending_units.push_back(byte_units[i]);
        end
    endtask

    initial begin
        int          pick;
        int          len;
        int          keep;
        logic [7:0]  lead;
        logic [7:0]  brk;
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_data  = 8'h00;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_ROWS[i]) feed_byte(DIR_ROWS[i].data, DIR_ROWS[i]);

        while (bytes_sent < N_DIRECTED + N_RANDOM) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                feed_byte(8'($urandom_range(0, 127)), '0);
            end else if (pick < 88) begin
                // mostly complete sequences, some cut short by a non-continuation byte
                len  = ($urandom_range(0, 9) < 8) ? $urandom_range(2, 4) : $urandom_range(5, 6);
                lead = (8'hFF << (8 - len)) | (8'($urandom) & (8'hFF >> (len + 1)));
                if (len == 4 && $urandom_range(0, 1) == 1)
                    lead = 8'($urandom_range(8'hF0, 8'hF4));
                keep = (pick < 75) ? len - 1 : $urandom_range(0, len - 2);
                feed_byte(lead, '0);
                repeat (keep) feed_byte(8'h80 | 8'($urandom_range(0, 63)), '0);
                if (pick >= 75) begin
                    brk = 8'($urandom);
                    if (brk[7:6] == 2'b10)
                        brk[6] = 1'b1;
                    feed_byte(brk, '0);
                end
            end else begin
                feed_byte(8'($urandom_range(0, 255)), '0);
            end
        end
        s_valid <= 1'b0;

        while (pending_units.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("run covered %0d input bytes (%0d directed) and %0d output units,",
                 bytes_sent, N_DIRECTED, units_checked);
        $display("with %0d surrogate pairs, %0d replacement units and one long output hold-off",
                 pairs_seen, repl_units);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // receiver: random short stalls, one long hold-off to back up the input
    initial begin
        int n;
        bit held;
        held     = 1'b0;
        rx_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && bytes_sent >= HOLD_AT) begin
                held = 1'b1;
                rx_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 4);
                rx_ready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                rx_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_unit want;
        if (o_m_axis_tvalid && rx_ready) begin
            if (pending_units.size() == 0) begin
                $display("%0t: unexpected unit, expected none, got code=%h repl=%b last=%b",
                         $time, o_m_axis_tdata, o_m_axis_tuser[0], o_m_axis_tlast);
                mismatches++;
            end else begin
                want = pending_units.pop_front();
                units_checked++;
                if (want.repl)
                    repl_units++;
                if (want.code !== o_m_axis_tdata || want.repl !== o_m_axis_tuser[0] ||
                    want.last !== o_m_axis_tlast) begin
                    $display("%0t: expected code=%h repl=%b last=%b, got code=%h repl=%b last=%b",
                             $time, want.code, want.repl, want.last,
                             o_m_axis_tdata, o_m_axis_tuser[0], o_m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && rx_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

endmodule
